// ===== hw/rtl/outlier_rejecting_window_mean_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the outlier-rejecting window mean unit
// Clocked on aclk and disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef OUTLIER_REJECTING_WINDOW_MEAN_UNIT_DEFINES_SVH
`define OUTLIER_REJECTING_WINDOW_MEAN_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define ORMW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define ORMW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ormw_pkg.sv =====
// ---------------------------------------------------------------------------
// ormw_pkg
// Shared widths, controller states and command/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package ormw_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W  = 10;
    localparam int KEPT_W    = 4;
    localparam int SUM_W     = 14;  // holds 16 * 1023
    localparam int DIV_W     = 5;   // divisor up to 16
    localparam int STEP_W    = 4;   // counts SUM_W divider steps
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [KEPT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_BAND,
        ST_FILT_GO,
        ST_FILT_WAIT,
        ST_OUT
    } ormw_state_t;

    typedef struct packed {
        logic shift_en;
        logic acc_clr;
        logic sum_en;
        logic band_en;
        logic idx_clr;
        logic div_start;
        logic mean_load;
        logic filt_load;
        logic filt_clr;
        logic out_load;
    } ormw_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_busy;
        logic band_zero;
        logic out_free;
    } ormw_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ormw_div.sv =====
// ---------------------------------------------------------------------------
// ormw_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ormw_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ormw_pkg::SUM_W-1:0]    dividend,
    input  wire logic [ormw_pkg::DIV_W-1:0]    divisor,
    output logic                               busy,
    output logic [ormw_pkg::SAMPLE_W-1:0]      quotient
);

    logic [ormw_pkg::STEP_W-1:0] step_reg, step_next;
    logic [ormw_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [ormw_pkg::SUM_W-1:0]  quo_reg, quo_next;
    logic [ormw_pkg::DIV_W-1:0]  dsr_reg, dsr_next;
    logic [ormw_pkg::DIV_W:0]    trial;
    logic [ormw_pkg::DIV_W:0]    diff;
    logic                        fits;

    // One trial subtraction per step.
    always_comb begin
        trial = {rem_reg, quo_reg[ormw_pkg::SUM_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_comb begin
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            step_next = ormw_pkg::STEP_W'(ormw_pkg::SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy) begin
            step_next = step_reg - 1'b1;
            rem_next  = fits ? diff[ormw_pkg::DIV_W-1:0] : trial[ormw_pkg::DIV_W-1:0];
            quo_next  = {quo_reg[ormw_pkg::SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // The quotient never exceeds the sample range.
    assign busy     = (step_reg != '0);
    assign quotient = quo_reg[ormw_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ormw_datapath.sv =====
// ---------------------------------------------------------------------------
// ormw_datapath
// Sample window, accumulators, band test, divider and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "outlier_rejecting_window_mean_unit_defines.svh"

module ormw_datapath #(
    parameter int WINDOW_LEN = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ormw_pkg::ormw_cmd_t             cmd,
    output ormw_pkg::ormw_stat_t                 stat,
    input  wire logic [ormw_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [ormw_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int MEAN_SHIFT = ormw_pkg::SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W    = ormw_pkg::SUM_W + 1;
    localparam int PROD_W     = ormw_pkg::SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((2 ** MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    logic [ormw_pkg::SAMPLE_W-1:0] win_reg [WINDOW_LEN];
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [ormw_pkg::SUM_W-1:0]    total_reg, total_next;
    logic [ormw_pkg::SUM_W-1:0]    bsum_reg, bsum_next;
    logic [CNT_W-1:0]              bcnt_reg, bcnt_next;
    logic [ormw_pkg::SAMPLE_W-1:0] mean_reg, mean_next;
    logic [ormw_pkg::SAMPLE_W-1:0] filt_reg, filt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ormw_pkg::SAMPLE_W-1:0] out_filt_reg;
    logic [ormw_pkg::SAMPLE_W-1:0] out_mean_reg;
    logic [ormw_pkg::KEPT_W-1:0]   out_kept_reg;

    logic [ormw_pkg::SAMPLE_W-1:0] cur;
    logic [ormw_pkg::SUM_W-1:0]    cur_ext, mean_ext, x10, m9, m11;
    logic                          in_band;
    logic [ormw_pkg::DIV_W-1:0]    cnt_ext;
    logic [ormw_pkg::KEPT_W-1:0]   kept;
    logic [PROD_W-1:0]             mean_prod;
    logic [ormw_pkg::SAMPLE_W-1:0] mean_quot;
    logic [ormw_pkg::SUM_W-1:0]    div_dividend;
    logic [ormw_pkg::DIV_W-1:0]    div_divisor;
    logic                          div_busy;
    logic [ormw_pkg::SAMPLE_W-1:0] div_quotient;

    // Window shift register, newest sample at entry zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.shift_en) begin
            win_reg[0] <= sample;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Entry under the scan index and the band test against the plain mean.
    always_comb begin
        cur      = win_reg[idx_reg];
        cur_ext  = ormw_pkg::SUM_W'(cur);
        mean_ext = ormw_pkg::SUM_W'(mean_reg);
        x10      = (cur_ext << 3) + (cur_ext << 1);
        m9       = (mean_ext << 3) + mean_ext;
        m11      = (mean_ext << 3) + (mean_ext << 1) + mean_ext;
        in_band  = !((x10 < m9) || (x10 > m11));
    end

    // Scan index and accumulators.
    always_comb begin
        idx_next   = idx_reg;
        total_next = total_reg;
        bsum_next  = bsum_reg;
        bcnt_next  = bcnt_reg;
        if (cmd.acc_clr) begin
            idx_next   = '0;
            total_next = '0;
            bsum_next  = '0;
            bcnt_next  = '0;
        end else if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.sum_en) begin
            total_next = total_reg + cur_ext;
            idx_next   = idx_reg + 1'b1;
        end else if (cmd.band_en) begin
            if (in_band) begin
                bsum_next = bsum_reg + cur_ext;
                bcnt_next = bcnt_reg + 1'b1;
            end
            idx_next = idx_reg + 1'b1;
        end
    end

    // Plain mean by multiplying with the rounded-up reciprocal of the window
    // length. The truncated quotient is exact for every total of SUM_W bits.
    always_comb begin
        mean_prod = PROD_W'(total_reg) * PROD_W'(MEAN_RECIP);
        mean_quot = mean_prod[MEAN_SHIFT +: ormw_pkg::SAMPLE_W];
    end

    // The divider forms the in-band sum over the in-band count.
    always_comb begin
        div_dividend = bsum_reg;
        div_divisor  = ormw_pkg::DIV_W'(bcnt_reg);
    end

    ormw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Mean registers.
    always_comb begin
        mean_next = cmd.mean_load ? mean_quot : mean_reg;
        filt_next = filt_reg;
        if (cmd.filt_clr) begin
            filt_next = '0;
        end else if (cmd.filt_load) begin
            filt_next = div_quotient;
        end
    end

    // Saturated kept count.
    always_comb begin
        cnt_ext = ormw_pkg::DIV_W'(bcnt_reg);
        kept    = (cnt_ext > ormw_pkg::DIV_W'(ormw_pkg::COUNT_MAX)) ?
                  ormw_pkg::COUNT_MAX : cnt_ext[ormw_pkg::KEPT_W-1:0];
    end

    // Output register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        bsum_reg  <= bsum_next;
        bcnt_reg  <= bcnt_next;
        mean_reg  <= mean_next;
        filt_reg  <= filt_next;
        if (cmd.out_load) begin
            out_filt_reg <= filt_reg;
            out_mean_reg <= mean_reg;
            out_kept_reg <= kept;
        end
    end

    // Status back to the controller.
    always_comb begin
        stat.idx_last  = (idx_reg == IDX_W'(WINDOW_LEN - 1));
        stat.div_busy  = div_busy;
        stat.band_zero = (bsum_reg == '0);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_kept_reg, out_mean_reg, out_filt_reg};

    // A division is never started on top of one in flight.
    `ORMW_ASSERT_IMP(a_div_start_idle, cmd.div_start, !div_busy,
        "divider started while busy")
    // Loading the output register always presents an item next cycle.
    `ORMW_ASSERT_NEXT(a_out_load_valid, cmd.out_load, m_tvalid,
        "output load did not raise m_tvalid")
    // The in-band count cannot exceed the window length.
    `ORMW_ASSERT_IMP(a_bcnt_range, cmd.filt_load, bcnt_reg <= CNT_W'(WINDOW_LEN),
        "in-band count above window length")

endmodule

`default_nettype wire

// ===== hw/rtl/ormw_ctrl.sv =====
// ---------------------------------------------------------------------------
// ormw_ctrl
// Controller state machine sequencing the two scans, the mean and the division.
// ---------------------------------------------------------------------------
`default_nettype none
`include "outlier_rejecting_window_mean_unit_defines.svh"

module ormw_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire ormw_pkg::ormw_stat_t  stat,
    output ormw_pkg::ormw_cmd_t        cmd
);

    ormw_pkg::ormw_state_t state_reg, state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ormw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ormw_pkg::ST_SUM;
                end
            end
            ormw_pkg::ST_SUM: begin
                if (stat.idx_last) begin
                    state_next = ormw_pkg::ST_MEAN;
                end
            end
            ormw_pkg::ST_MEAN: begin
                state_next = ormw_pkg::ST_BAND;
            end
            ormw_pkg::ST_BAND: begin
                if (stat.idx_last) begin
                    state_next = ormw_pkg::ST_FILT_GO;
                end
            end
            ormw_pkg::ST_FILT_GO: begin
                state_next = stat.band_zero ? ormw_pkg::ST_OUT : ormw_pkg::ST_FILT_WAIT;
            end
            ormw_pkg::ST_FILT_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ormw_pkg::ST_OUT;
                end
            end
            ormw_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ormw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ormw_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ormw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.shift_en = 1'b1;
                    cmd.acc_clr  = 1'b1;
                end
            end
            ormw_pkg::ST_SUM: begin
                cmd.sum_en = 1'b1;
            end
            ormw_pkg::ST_MEAN: begin
                cmd.mean_load = 1'b1;
                cmd.idx_clr   = 1'b1;
            end
            ormw_pkg::ST_BAND: begin
                cmd.band_en = 1'b1;
            end
            ormw_pkg::ST_FILT_GO: begin
                if (stat.band_zero) begin
                    cmd.filt_clr = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            ormw_pkg::ST_FILT_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.filt_load = 1'b1;
                end
            end
            ormw_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ormw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Only one item is in work at a time.
    `ORMW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
        "second item accepted while one is in work")

endmodule

`default_nettype wire

// ===== hw/rtl/outlier_rejecting_window_mean_unit.sv =====
// Flow: each accepted item runs two window scans at one entry per cycle, a reciprocal
// multiply for the mean and a 14-step restoring division, which is skipped when the
// in-band sum is zero; the result then waits while the output register stays full. A new
// item is accepted only after the previous result is loaded into the output register.
// Reset: synchronous active-low aresetn clears the window to zero, the controller and
// the output valid flag.
// ---------------------------------------------------------------------------
// outlier_rejecting_window_mean_unit
// Trimmed moving average: plain window mean and mean of entries within 10%.
// ---------------------------------------------------------------------------
`default_nettype none

module outlier_rejecting_window_mean_unit #(
    parameter int WINDOW_LEN = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [9:0] sample
    input  wire logic [ormw_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [9:0] filtered_mean, [19:10] window_mean, [23:20] kept_count
    output logic [ormw_pkg::M_TDATA_W-1:0]       m_tdata
);

    ormw_pkg::ormw_cmd_t  cmd;
    ormw_pkg::ormw_stat_t stat;

    ormw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ormw_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .sample   (s_tdata[ormw_pkg::SAMPLE_W-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
